FILE: rtl/sdfp_pkg.sv
// shared types and character constants for the event-stream data field parser
`default_nettype none

package sdfp_pkg;

    // line parser position
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_NAME  = 2'd1,
        MODE_VALUE = 2'd2,
        MODE_SKIP  = 2'd3
    } mode_t;

    // result word kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_MARKER  = 1'b1;

    // input word ops
    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // length of the field name that is passed on
    localparam logic [2:0] NAME_LEN = 3'd4;

    // one queued result word
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    // characters of the field name "data"
    function automatic logic [7:0] name_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h64;
            2'd1:    c = 8'h61;
            2'd2:    c = 8'h74;
            2'd3:    c = 8'h61;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sse_data_field_parser_top.sv
// event-stream data field parser: line state machine and two-word result queue
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid s_ready s_op s_in_byte      | in
//  result  | m_valid m_ready m_kind m_out_byte   | out
//          | m_last                              |
//
// one input word per cycle while s_ready is high; its results sit in the result queue in the next cycle.
// a word that yields two results (held CR plus a payload byte, or joining LF
// or held CR plus event marker) holds the input until its first result leaves.
// s_ready is high when the queue is empty, or holds one word that leaves now.
// aresetn clears the line state, the event flags and the queue.
`default_nettype none

module sse_data_field_parser_top
    import sdfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_op,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_kind,
    output logic [7:0]      m_out_byte,
    output logic            m_last
);

    // line and event state
    mode_t      mode_reg, mode_next;
    logic [2:0] pos_reg, pos_next;
    logic       mismatch_reg, mismatch_next;
    logic       skip_sp_reg, skip_sp_next;
    logic       cr_reg, cr_next;
    logic       open_reg, open_next;
    logic       nonempty_reg, nonempty_next;

    // result queue
    result_t    slot_reg [2];
    result_t    slot_next [2];
    logic [1:0] count_reg, count_next;

    // per-word results
    result_t    res [2];
    logic [1:0] n_res;
    logic       is_data;
    logic       accept;
    logic       pop;
    logic [7:0] b;

    assign b      = s_in_byte;
    assign pop    = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);
    assign accept = s_valid && s_ready;

    // word step: next line state and results
    always_comb begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        mismatch_next = mismatch_reg;
        skip_sp_next  = skip_sp_reg;
        cr_next       = cr_reg;
        open_next     = open_reg;
        nonempty_next = nonempty_reg;
        res[0]        = '{kind: KIND_PAYLOAD, value: 8'h00, last: 1'b0};
        res[1]        = '{kind: KIND_PAYLOAD, value: 8'h00, last: 1'b0};
        n_res         = 2'd0;
        is_data       = 1'b0;

        if (s_op == OP_FINISH) begin
            if (mode_reg == MODE_VALUE && cr_reg) begin
                res[n_res[0]] = '{kind: KIND_PAYLOAD, value: CHAR_CR, last: 1'b0};
                n_res = n_res + 2'd1;
                nonempty_next = 1'b1;
            end else if (mode_reg == MODE_NAME || (mode_reg == MODE_START && cr_reg)) begin
                // trailing name that may still be the data field
                is_data = !mismatch_reg && !cr_reg && (pos_reg == NAME_LEN);
                if (is_data) begin
                    if (nonempty_next) begin
                        res[n_res[0]] = '{kind: KIND_PAYLOAD, value: CHAR_LF, last: 1'b0};
                        n_res = n_res + 2'd1;
                    end
                    open_next = 1'b1;
                end
            end
            // close the event
            if (open_next) begin
                res[n_res[0]] = '{kind: KIND_MARKER, value: 8'h00, last: 1'b0};
                n_res = n_res + 2'd1;
            end
            open_next     = 1'b0;
            nonempty_next = 1'b0;
            mode_next     = MODE_START;
            pos_next      = 3'd0;
            mismatch_next = 1'b0;
            skip_sp_next  = 1'b0;
            cr_next       = 1'b0;
        end else if (mode_reg == MODE_SKIP) begin
            if (b == CHAR_LF) begin
                mode_next = MODE_START;
                pos_next = 3'd0;
                mismatch_next = 1'b0;
                skip_sp_next = 1'b0;
                cr_next = 1'b0;
            end
        end else if (mode_reg == MODE_VALUE) begin
            if (b == CHAR_LF) begin
                mode_next = MODE_START;
                pos_next = 3'd0;
                mismatch_next = 1'b0;
                skip_sp_next = 1'b0;
                cr_next = 1'b0;
            end else begin
                // a held CR that is not followed by LF is payload
                if (cr_reg) begin
                    res[n_res[0]] = '{kind: KIND_PAYLOAD, value: CHAR_CR, last: 1'b0};
                    n_res = n_res + 2'd1;
                    nonempty_next = 1'b1;
                end
                cr_next = 1'b0;
                if (b == CHAR_CR) begin
                    cr_next = 1'b1;
                end else if (!(skip_sp_reg && b == CHAR_SPACE)) begin
                    res[n_res[0]] = '{kind: KIND_PAYLOAD, value: b, last: 1'b0};
                    n_res = n_res + 2'd1;
                    nonempty_next = 1'b1;
                end
                skip_sp_next = 1'b0;
            end
        end else begin
            // line start or field name
            if (mode_reg == MODE_START && !cr_reg && b == CHAR_COLON) begin
                mode_next = MODE_SKIP;
            end else if (mode_reg == MODE_START && b == CHAR_LF) begin
                // blank line
                if (open_reg) begin
                    res[n_res[0]] = '{kind: KIND_MARKER, value: 8'h00, last: 1'b0};
                    n_res = n_res + 2'd1;
                end
                open_next     = 1'b0;
                nonempty_next = 1'b0;
                mode_next     = MODE_START;
                pos_next      = 3'd0;
                mismatch_next = 1'b0;
                skip_sp_next  = 1'b0;
                cr_next       = 1'b0;
            end else if (b == CHAR_LF || b == CHAR_COLON) begin
                // end of field name
                is_data = !mismatch_reg && !cr_reg && (pos_reg == NAME_LEN);
                if (is_data) begin
                    if (nonempty_reg) begin
                        res[n_res[0]] = '{kind: KIND_PAYLOAD, value: CHAR_LF, last: 1'b0};
                        n_res = n_res + 2'd1;
                    end
                    open_next = 1'b1;
                end
                cr_next       = 1'b0;
                mismatch_next = mismatch_reg || cr_reg;
                if (b == CHAR_LF) begin
                    mode_next     = MODE_START;
                    pos_next      = 3'd0;
                    mismatch_next = 1'b0;
                    skip_sp_next  = 1'b0;
                end else if (is_data) begin
                    mode_next    = MODE_VALUE;
                    skip_sp_next = 1'b1;
                end else begin
                    mode_next = MODE_SKIP;
                end
            end else begin
                // name byte; a held CR spoils the name
                if (cr_reg) begin
                    mismatch_next = 1'b1;
                    cr_next       = 1'b0;
                    mode_next     = MODE_NAME;
                end
                if (b == CHAR_CR) begin
                    cr_next = 1'b1;
                end else begin
                    mode_next = MODE_NAME;
                    if (pos_reg < NAME_LEN && b == name_char(pos_reg[1:0])) begin
                        pos_next = pos_reg + 3'd1;
                    end else begin
                        mismatch_next = 1'b1;
                    end
                end
            end
        end

        // flag the final result of this word
        if (n_res == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n_res == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    // result queue update
    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_next   = count_reg;
        if (accept) begin
            slot_next[0] = res[0];
            slot_next[1] = res[1];
            count_next   = n_res;
        end else if (pop) begin
            slot_next[0] = slot_reg[1];
            count_next   = count_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_START;
            pos_reg      <= 3'd0;
            mismatch_reg <= 1'b0;
            skip_sp_reg  <= 1'b0;
            cr_reg       <= 1'b0;
            open_reg     <= 1'b0;
            nonempty_reg <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            if (accept) begin
                mode_reg     <= mode_next;
                pos_reg      <= pos_next;
                mismatch_reg <= mismatch_next;
                skip_sp_reg  <= skip_sp_next;
                cr_reg       <= cr_next;
                open_reg     <= open_next;
                nonempty_reg <= nonempty_next;
            end
            count_reg <= count_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    // result port
    assign m_valid    = (count_reg != 2'd0);
    assign m_kind     = slot_reg[0].kind;
    assign m_out_byte = slot_reg[0].value;
    assign m_last     = slot_reg[0].last;

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue overfilled");

    a_second_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> (slot_reg[1].last && !slot_reg[0].last))
        else $error("two-word result flagged wrongly");

    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_MARKER) |-> (m_out_byte == 8'h00 && m_last))
        else $error("event marker malformed");

    a_nonempty_open: assert property (@(posedge aclk) disable iff (!aresetn)
        nonempty_reg |-> open_reg)
        else $error("payload seen outside an open event");

    a_finish_resets_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_FINISH) |=>
            (mode_reg == MODE_START && !cr_reg && !open_reg && !nonempty_reg))
        else $error("finish did not reset line state");

endmodule

`default_nettype wire
